FILE: rtl/oaht_pkg.sv
`default_nettype none
package oaht_pkg;
    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_VALUE_BITS = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int HASH_W         = 32;
    localparam int WORD_W         = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_DEAD  = 2'd2;

    // request class decided in the front end
    localparam logic [1:0] CLS_INS  = 2'd0;
    localparam logic [1:0] CLS_FIND = 2'd1;
    localparam logic [1:0] CLS_DEL  = 2'd2;
    localparam logic [1:0] CLS_NOP  = 2'd3;

    typedef struct packed {
        logic [1:0]        cls;
        logic [HASH_W-1:0] key_hash;
        logic [WORD_W-1:0] key_word;
        logic [WORD_W-1:0] value_word;
    } req_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_stat_t;
endpackage
`default_nettype wire

FILE: rtl/oaht_ram.sv
`default_nettype none
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/oaht_front.sv
`default_nettype none
module oaht_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          opcode,
    input  wire logic [31:0]         key_hash,
    input  wire logic [63:0]         key_word,
    input  wire logic [63:0]         value_word,
    output logic                     busy,
    input  wire oaht_pkg::back_stat_t stat,
    output logic                     q_valid,
    output oaht_pkg::req_t           q_head
);
    import oaht_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    req_t          q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          push;
    logic [1:0]    cls;

    always_comb
    begin
        unique case (opcode)
            OP_INSERT: cls = CLS_INS;
            OP_LOOKUP: cls = CLS_FIND;
            OP_DELETE: cls = CLS_DEL;
            default:   cls = CLS_NOP;
        endcase
    end

    assign busy    = stat.clearing || (cnt_reg == CW'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_head  = q_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= '{cls: cls, key_hash: key_hash,
                                 key_word: key_word, value_word: value_word};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (stat.pop)
            begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(stat.pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/oaht_back.sv
`default_nettype none
module oaht_back #(
    parameter int SLOTS      = oaht_pkg::DEF_SLOTS,
    parameter int KEY_BITS   = oaht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = oaht_pkg::DEF_VALUE_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire oaht_pkg::req_t       q_head,
    output oaht_pkg::back_stat_t      stat,
    output logic                      done,
    output logic [1:0]                status,
    output logic [63:0]               found_value
);
    import oaht_pkg::*;

    localparam int AW    = $clog2(SLOTS);
    localparam int LIMIT = SLOTS + 8;
    localparam int NW    = $clog2(LIMIT + 1);
    localparam int LW    = $clog2(SLOTS + 1);
    localparam int MW    = LW + 3;
    localparam int DW    = HASH_W + KEY_BITS + VALUE_BITS;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [HASH_W-1:0]     pert_reg, pert_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [LW-1:0]         live_reg, live_next;
    logic [1:0]            cls_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  done_reg, done_next;
    logic [1:0]            status_reg, status_next;
    logic [63:0]           found_reg, found_next;

    logic                  mark_we, data_we;
    logic [AW-1:0]         mark_waddr;
    logic [1:0]            mark_wdata, mark_rd;
    logic [DW-1:0]         data_rd;
    logic [HASH_W-1:0]     rd_hash;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [MW-1:0]         load3;
    logic                  room, pop, last;
    logic [AW-1:0]         pos_step;

    oaht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
        .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
        .raddr(pos_reg), .rdata(mark_rd)
    );

    oaht_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data (
        .clk(clk), .we(data_we), .waddr(pos_reg),
        .wdata({hash_reg, key_reg, val_reg}),
        .raddr(pos_reg), .rdata(data_rd)
    );

    assign {rd_hash, rd_key, rd_val} = data_rd;
    assign load3    = MW'({live_reg, 1'b0}) + MW'(live_reg) + MW'(1);
    assign room     = (load3 <= MW'(2 * SLOTS));
    assign last     = (n_reg == NW'(LIMIT - 1));
    assign pos_step = (pos_reg << 2) + pos_reg + pert_reg[AW-1:0] + AW'(1);
    assign pop      = (state_reg == S_IDLE) && q_valid;

    assign stat.clearing = (state_reg == S_CLEAR);
    assign stat.pop      = pop;
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_value   = found_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        pert_next   = pert_reg;
        n_next      = n_reg;
        live_next   = live_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        found_next  = '0;
        mark_we     = 1'b0;
        mark_waddr  = pos_reg;
        mark_wdata  = MARK_LIVE;
        data_we     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = MARK_EMPTY;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == AW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    pos_next  = q_head.key_hash[AW-1:0];
                    pert_next = q_head.key_hash;
                    n_next    = '0;
                    if (q_head.cls == CLS_NOP)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                    end
                    else if (q_head.cls == CLS_INS && !room)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (cls_reg == CLS_INS && mark_rd != MARK_LIVE)
                begin
                    mark_we     = 1'b1;
                    data_we     = 1'b1;
                    live_next   = live_reg + 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else if (cls_reg != CLS_INS && mark_rd == MARK_EMPTY)
                begin
                    done_next   = 1'b1;
                    status_next = ST_MISS;
                    state_next  = S_IDLE;
                end
                else if (cls_reg != CLS_INS && mark_rd == MARK_LIVE &&
                         rd_hash == hash_reg && rd_key == key_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    found_next  = 64'(rd_val);
                    state_next  = S_IDLE;
                    if (cls_reg == CLS_DEL)
                    begin
                        mark_we    = 1'b1;
                        mark_wdata = MARK_DEAD;
                        live_next  = live_reg - 1'b1;
                    end
                end
                else if (last)
                begin
                    done_next   = 1'b1;
                    status_next = (cls_reg == CLS_INS) ? ST_FULL : ST_MISS;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next   = pos_step;
                    pert_next  = pert_reg >> 5;
                    n_next     = n_reg + 1'b1;
                    state_next = S_READ;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cls_reg  <= q_head.cls;
            hash_reg <= q_head.key_hash;
            key_reg  <= q_head.key_word[KEY_BITS-1:0];
            val_reg  <= q_head.value_word[VALUE_BITS-1:0];
        end
        pos_reg    <= pos_next;
        pert_reg   <= pert_next;
        n_reg      <= n_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            live_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            live_reg  <= live_next;
            done_reg  <= done_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/open_address_hash_table_top.sv
`default_nettype none
// Open-addressing key/value table with perturbed probing.
// Request channel: a transaction is taken at a rising edge with start high
// and busy low; opcode, key_hash, key_word and value_word travel with it.
// Response channel: done is high for one cycle with status and found_value;
// the receiver cannot stall, so every response is taken when shown.
// found_value is zero whenever done is low or status is not ok.
// The front end classifies requests into a 2-entry queue; busy rises when
// the queue is full. The back end runs one request at a time.
// Sequencing: an ignored opcode or a refused insert is answered from the
// idle state without probing; any other request probes slots in turn, each
// probe being a mark/data RAM read (S_READ) and then a compare (S_CHECK).
// Reset: after rst_n releases, a clearing pass writes every slot mark empty,
// one slot per cycle; busy stays high during it. The live-slot count
// (live_reg) resets to zero.
// An insert is refused with status full when 3*live+1 exceeds 2*SLOTS.
module open_address_hash_table_top #(
    parameter int SLOTS      = oaht_pkg::DEF_SLOTS,
    parameter int KEY_BITS   = oaht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = oaht_pkg::DEF_VALUE_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] key_hash,
    input  wire logic [63:0] key_word,
    input  wire logic [63:0] value_word,
    output logic             done,
    output logic [1:0]       status,
    output logic [63:0]      found_value
);
    import oaht_pkg::*;

    back_stat_t stat;
    logic       q_valid;
    req_t       q_head;

    // front end: accept and classify, buffer in a short queue
    oaht_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .opcode(opcode),
        .key_hash(key_hash), .key_word(key_word), .value_word(value_word),
        .busy(busy), .stat(stat), .q_valid(q_valid), .q_head(q_head)
    );

    // back end: probe sequencer over slot RAMs
    oaht_back #(
        .SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head),
        .stat(stat), .done(done), .status(status), .found_value(found_value)
    );
endmodule
`default_nettype wire

FILE: rtl/oaht_checker.sv
`default_nettype none
module oaht_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [63:0] found_value
);
    import oaht_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
        else $error("bad status code");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (found_value == 64'd0))
        else $error("found_value not zero while idle");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (found_value == 64'd0))
        else $error("found_value not zero on failed transaction");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> busy)
        else $error("busy low right after reset");
endmodule

bind open_address_hash_table_top oaht_checker u_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done),
    .status(status), .found_value(found_value)
);
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import oaht_pkg::*;

    localparam int NSLOTS     = DEF_SLOTS;
    localparam int PROBE_MAX  = NSLOTS + 8;
    localparam int STALL_MAX  = 20000;   // covers the clearing pass and the longest probe run
    localparam int MAX_GAP    = 12;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] value;
    } answer_t;

    typedef struct {
        logic [31:0] hash;
        logic [63:0] key;
    } entry_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [31:0] key_hash;
    logic [63:0] key_word;
    logic [63:0] value_word;
    logic        done;
    logic [1:0]  status;
    logic [63:0] found_value;

    open_address_hash_table_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .key_hash(key_hash), .key_word(key_word),
        .value_word(value_word), .done(done), .status(status),
        .found_value(found_value)
    );

    // Shadow copy of the table
    logic [1:0]  shadow_mark [NSLOTS];
    logic [31:0] shadow_hash [NSLOTS];
    logic [63:0] shadow_key  [NSLOTS];
    logic [63:0] shadow_value[NSLOTS];
    int unsigned shadow_live;

    answer_t pending_answers[$];
    entry_t  stored_keys[$];
    int      errors;
    int      n_insert, n_lookup, n_delete, n_ignored, n_full, n_hit, n_miss;
    int      idle_cycles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Expected answer for one request; updates the shadow table.
    task automatic table_apply(input logic [1:0] op, input logic [31:0] h,
                               input logic [63:0] k, input logic [63:0] v,
                               output answer_t ans);
        logic [31:0] pos;
        logic [31:0] perturb;
        logic [9:0]  idx;
        int          hit;
        ans.status = ST_MISS;
        ans.value  = '0;
        pos = h;
        perturb = h;
        hit = -1;
        if (op == OP_INSERT) begin
            ans.status = ST_FULL;
            if (shadow_live * 3 + 1 <= NSLOTS * 2) begin
                for (int n = 0; n < PROBE_MAX; n++) begin
                    idx = pos[9:0];
                    if (shadow_mark[idx] != MARK_LIVE) begin
                        shadow_mark[idx]  = MARK_LIVE;
                        shadow_hash[idx]  = h;
                        shadow_key[idx]   = k;
                        shadow_value[idx] = v;
                        shadow_live++;
                        ans.status = ST_OK;
                        break;
                    end
                    pos = pos * 5 + perturb + 1;
                    perturb = perturb >> 5;
                end
            end
        end
        else if (op == OP_LOOKUP || op == OP_DELETE) begin
            for (int n = 0; n < PROBE_MAX; n++) begin
                idx = pos[9:0];
                if (shadow_mark[idx] == MARK_EMPTY)
                    break;
                if (shadow_mark[idx] == MARK_LIVE && shadow_hash[idx] == h &&
                    shadow_key[idx] == k) begin
                    hit = idx;
                    break;
                end
                pos = pos * 5 + perturb + 1;
                perturb = perturb >> 5;
            end
            if (hit >= 0) begin
                ans.status = ST_OK;
                ans.value  = shadow_value[hit];
                if (op == OP_DELETE) begin
                    shadow_mark[hit] = MARK_DEAD;
                    if (shadow_live > 0)
                        shadow_live--;
                end
            end
        end
    endtask

    // Drive one transaction; start stays high afterwards so back-to-back
    // requests never drop it within a step.
    task automatic send_request(input logic [1:0] op, input logic [31:0] h,
                                input logic [63:0] k, input logic [63:0] v);
        int      gap;
        answer_t ans;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start      <= 1'b1;
        opcode     <= op;
        key_hash   <= h;
        key_word   <= k;
        value_word <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        table_apply(op, h, k, v, ans);
        pending_answers.push_back(ans);
        case (op)
            OP_INSERT: n_insert++;
            OP_LOOKUP: n_lookup++;
            OP_DELETE: n_delete++;
            default:   n_ignored++;
        endcase
        if (op == OP_INSERT && ans.status == ST_FULL) n_full++;
        if ((op == OP_LOOKUP || op == OP_DELETE) && ans.status == ST_OK) n_hit++;
        if ((op == OP_LOOKUP || op == OP_DELETE) && ans.status == ST_MISS) n_miss++;
    endtask

    // Hold off until every outstanding response has come back.
    task automatic drain_responses();
        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Hashes drawn from a narrow set half of the time so probe chains form.
    function automatic logic [31:0] pick_hash();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 31);
            2:       return {22'($urandom_range(0, 7)), 10'h155};
            default: return $urandom() & 32'hFFFF_F3FF;
        endcase
    endfunction

    task automatic insert_new(input logic [31:0] h);
        entry_t e;
        e.hash = h;
        e.key  = rand64();
        send_request(OP_INSERT, e.hash, e.key, rand64());
        stored_keys.push_back(e);
    endtask

    // Field extremes, tombstone skipping, duplicates, absent keys, opcode 3.
    task automatic test_basic_ops();
        send_request(OP_INSERT, 32'h0, 64'h0, 64'h0);
        send_request(OP_INSERT, '1, '1, '1);
        send_request(OP_LOOKUP, 32'h0, 64'h0, '1);
        send_request(OP_LOOKUP, '1, '1, 64'h0);
        send_request(OP_LOOKUP, '1, 64'h1234, 64'h0);       // same hash, other key
        send_request(OP_DELETE, 32'h0, 64'h55, 64'h0);       // absent key
        send_request(OP_LOOKUP, 32'h77, 64'h0, 64'h0);       // empty chain
        // duplicate insert: the first copy wins until it is deleted
        send_request(OP_INSERT, 32'h40, 64'hA5A5, 64'h1111);
        send_request(OP_INSERT, 32'h40, 64'hA5A5, 64'h2222);
        send_request(OP_LOOKUP, 32'h40, 64'hA5A5, 64'h0);
        send_request(OP_DELETE, 32'h40, 64'hA5A5, 64'h0);
        send_request(OP_LOOKUP, 32'h40, 64'hA5A5, 64'h0);    // skips the tombstone
        send_request(OP_INSERT, 32'h40, 64'h5A5A, 64'h3333); // reuses the tombstone
        send_request(OP_LOOKUP, 32'h40, 64'h5A5A, 64'h0);
        send_request(OP_DELETE, 32'h40, 64'hA5A5, 64'h0);
        send_request(OP_DELETE, 32'h40, 64'hA5A5, 64'h0);    // now absent
        send_request(2'd3, '1, '1, '1);                      // ignored opcode
        send_request(OP_DELETE, '1, '1, 64'h0);
        send_request(OP_DELETE, 32'h0, 64'h0, 64'h0);
        drain_responses();
    endtask

    // Fill to the load limit with lookups mixed in, then four requests more (inserts refused).
    task automatic test_load_limit();
        int extra;
        extra = 0;
        while (extra < 4) begin
            if (shadow_live * 3 + 1 > NSLOTS * 2)
                extra++;
            if ($urandom_range(0, 9) == 0 && stored_keys.size() != 0) begin
                entry_t e;
                e = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                send_request(OP_LOOKUP, e.hash, e.key, rand64());
            end
            else
                insert_new(pick_hash());
        end
        drain_responses();
    endtask

    // Mixed traffic, mostly on known keys so hits and deletes are common.
    task automatic test_random_mix(input int count);
        int     sel;
        int     pick;
        entry_t e;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                insert_new(($urandom_range(0, 3) == 0 && stored_keys.size() != 0) ?
                           stored_keys[$urandom_range(0, stored_keys.size() - 1)].hash :
                           pick_hash());
            else if (sel < 95 && stored_keys.size() != 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, stored_keys.size() - 1);
                e = stored_keys[pick];
                if (sel < 65)
                    send_request(OP_LOOKUP, e.hash, e.key, rand64());
                else begin
                    send_request(OP_DELETE, e.hash, e.key, rand64());
                    stored_keys.delete(pick);
                end
            end
            else if (sel < 95)
                send_request((sel < 65) ? OP_LOOKUP : OP_DELETE, pick_hash(), rand64(), rand64());
            else
                send_request(2'd3, $urandom(), rand64(), rand64());
            if (i == count / 2)
                drain_responses();
        end
    endtask

    // Response checker: every done pulse must match the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected response status=%0d value=%h",
                         $time, status, found_value);
            end
            else begin
                answer_t ans;
                ans = pending_answers.pop_front();
                if (status !== ans.status) begin
                    errors++;
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, ans.status, status);
                end
                if (found_value !== ans.value) begin
                    errors++;
                    $display("%0t: found_value mismatch expected=%h actual=%h",
                             $time, ans.value, found_value);
                end
            end
        end
    end

    // Watchdog: cycles with neither a request nor a response taken.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_MAX) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_INSERT;
        key_hash = '0;
        key_word = '0;
        value_word = '0;
        errors = 0;
        idle_cycles = 0;
        n_insert = 0; n_lookup = 0; n_delete = 0; n_ignored = 0;
        n_full = 0; n_hit = 0; n_miss = 0;
        shadow_live = 0;
        for (int i = 0; i < NSLOTS; i++) begin
            shadow_mark[i]  = MARK_EMPTY;
            shadow_hash[i]  = '0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_load_limit();
        test_random_mix(840);
        drain_responses();
        repeat (50) @(negedge clk);

        $display("Covered %0d inserts (%0d refused full), %0d lookups, %0d deletes, %0d ignored",
                 n_insert, n_full, n_lookup, n_delete, n_ignored);
        $display("Searches: %0d hits, %0d misses; %0d slots live at end",
                 n_hit, n_miss, shadow_live);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/oaht_pkg.sv
rtl/oaht_ram.sv
rtl/oaht_front.sv
rtl/oaht_back.sv
rtl/open_address_hash_table_top.sv
rtl/oaht_checker.sv
sim/testbench.sv
